// ===== rtl/core/ede_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_pkg
// Shared widths, payload structs and state types of the distance engine.
// ----------------------------------------------------------------------------
package ede_pkg;

   localparam int ELEM_W             = 8;
   localparam int SQ_W               = 2 * ELEM_W;
   localparam int SUM_W              = 23;
   localparam int ROOT_W             = 20;
   localparam int FRAC_W             = 8;
   localparam int SQ_MAX             = 65025;
   localparam int SUM_FIELD_MAX      = (1 << SUM_W) - 1;
   localparam int VECTOR_DIM_DEFAULT = 128;
   localparam int QUEUE_DEPTH        = 2;

   typedef struct packed {
      logic [ELEM_W-1:0] elem_a;
      logic [ELEM_W-1:0] elem_b;
      logic              last;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0]  squared_sum;
      logic [ROOT_W-1:0] distance_q8;
      logic              overlong;
   } rsp_type;

   typedef struct packed {
      logic [SUM_W-1:0] squared_sum;
      logic             overlong;
   } entry_type;

   typedef enum logic [0:0] {
      SQRT_IDLE,
      SQRT_CALC
   } sqrt_state_type;

endpackage

// ===== rtl/core/ede_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_front
// Accumulates squared element differences and hands finished vectors on.
// ----------------------------------------------------------------------------
module ede_front #(
   parameter int VECTOR_DIM = ede_pkg::VECTOR_DIM_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ede_pkg::req_type   req_data,
   output logic               push,
   output ede_pkg::entry_type push_data,
   input  logic               queue_full
);
   import ede_pkg::*;

   localparam longint SUM_FULL = longint'(SQ_MAX) * longint'(VECTOR_DIM);
   localparam logic [SUM_W-1:0] SUM_CAP =
      SUM_W'((SUM_FULL < longint'(SUM_FIELD_MAX)) ? SUM_FULL : longint'(SUM_FIELD_MAX));
   localparam int CNT_W = $clog2(VECTOR_DIM + 1);
   localparam logic [CNT_W-1:0] DIM_CNT = CNT_W'(VECTOR_DIM);

   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;
   logic [ELEM_W-1:0] diff;
   logic [SQ_W-1:0]   sq;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_sat;
   logic              at_dim;
   logic              ovf_now;
   logic              accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      diff     = (req_data.elem_a > req_data.elem_b) ? (req_data.elem_a - req_data.elem_b)
                                                     : (req_data.elem_b - req_data.elem_a);
      sq       = SQ_W'(diff) * SQ_W'(diff);
      sum_wide = {1'b0, acc_ff} + (SUM_W + 1)'(sq);
      sum_sat  = (sum_wide > {1'b0, SUM_CAP}) ? SUM_CAP : sum_wide[SUM_W-1:0];
      at_dim   = (cnt_ff == DIM_CNT);
      ovf_now  = ovf_ff || at_dim;

      acc_in = acc_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (req_data.last) begin
            acc_in = '0;
            cnt_in = '0;
            ovf_in = 1'b0;
         end else begin
            acc_in = sum_sat;
            cnt_in = at_dim ? cnt_ff : cnt_ff + 1'b1;
            ovf_in = ovf_now;
         end
      end

      push                  = accept && req_data.last;
      push_data.squared_sum = sum_sat;
      push_data.overlong    = ovf_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule

// ===== rtl/core/ede_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_queue
// Short first-in first-out queue of finished sums between front and back.
// ----------------------------------------------------------------------------
module ede_queue #(
   parameter int DEPTH = ede_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ede_pkg::entry_type push_data,
   output logic               full,
   input  logic               pop,
   output ede_pkg::entry_type pop_data,
   output logic               empty
);
   import ede_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

   entry_type        mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (fill_ff == DEPTH_CNT);
   assign empty    = (fill_ff == '0);
   assign pop_data = mem[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ===== rtl/core/ede_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ede_back
// Bit-serial square root of the sum in 8-bit fixed point, one root bit per
// cycle (the last bit waits for a free output register), with a registered result beat.
// ----------------------------------------------------------------------------
module ede_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  ede_pkg::entry_type pop_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ede_pkg::rsp_type   rsp_data
);
   import ede_pkg::*;

   localparam int OPND_W = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 2;
   localparam int WORK_W = REM_W + 2;
   localparam int ITER_W = $clog2(ROOT_W);
   localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(ROOT_W - 1);

   sqrt_state_type    state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [OPND_W-1:0] opnd_ff, opnd_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              ovf_ff, ovf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic [WORK_W-1:0] rem_shift;
   logic [WORK_W-1:0] trial;
   logic              fits;
   logic [REM_W-1:0]  rem_step;
   logic [ROOT_W-1:0] root_step;
   logic              out_free;
   logic              last_iter;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      rem_shift = {rem_ff, opnd_ff[OPND_W-1 -: 2]};
      trial     = {2'b00, root_ff, 2'b01};
      fits      = (rem_shift >= trial);
      rem_step  = fits ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
      root_step = {root_ff[ROOT_W-2:0], fits};
      out_free  = !rsp_valid_ff || rsp_ready;
      last_iter = (iter_ff == LAST_ITER);
   end

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      opnd_in      = opnd_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      sum_in       = sum_ff;
      ovf_in       = ovf_ff;
      pop          = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         SQRT_IDLE: begin
            if (!empty) begin
               pop      = 1'b1;
               opnd_in  = {1'b0, pop_data.squared_sum, {(OPND_W - SUM_W - 1){1'b0}}};
               rem_in   = '0;
               root_in  = '0;
               iter_in  = '0;
               sum_in   = pop_data.squared_sum;
               ovf_in   = pop_data.overlong;
               state_in = SQRT_CALC;
            end
         end
         SQRT_CALC: begin
            if (!last_iter || out_free) begin
               opnd_in = {opnd_ff[OPND_W-3:0], 2'b00};
               rem_in  = rem_step;
               root_in = root_step;
               iter_in = iter_ff + 1'b1;
               if (last_iter) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.squared_sum  = sum_ff;
                  rsp_data_in.distance_q8  = root_step;
                  rsp_data_in.overlong     = ovf_ff;
                  state_in                 = SQRT_IDLE;
               end
            end
         end
         default: begin
            state_in = SQRT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SQRT_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opnd_ff     <= opnd_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      sum_ff      <= sum_in;
      ovf_ff      <= ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ===== rtl/core/euclidean_distance_engine.sv =====
`timescale 1ns / 1ps
// Takes one element pair beat per cycle while the queue is not full; each beat
// is added into a registered accumulator. When idle, the root unit pops a sum,
// then resolves the root one bit per cycle over 20 bits, the final bit waiting
// for a free result register. The root unit works on one sum at a time; a
// two-entry queue holds finished sums, and the input stalls only while it is full.
// Synchronous reset clears the accumulator, pair count, queue and root unit.
// ----------------------------------------------------------------------------
// euclidean_distance_engine
// Streaming squared-distance accumulator with fixed-point square root.
// ----------------------------------------------------------------------------
module euclidean_distance_engine #(
   parameter int VECTOR_DIM = ede_pkg::VECTOR_DIM_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ede_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ede_pkg::rsp_type rsp_data
);
   import ede_pkg::*;

   logic      push;
   entry_type push_data;
   logic      queue_full;
   logic      pop;
   entry_type pop_data;
   logic      queue_empty;

   ede_front #(
      .VECTOR_DIM (VECTOR_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .push_data  (push_data),
      .queue_full (queue_full)
   );

   ede_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   ede_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (queue_empty),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
